/* rtl/core/pointer_shake_detector_defines.svh */
// Assertion macros for the pointer shake detector.
// Assertions compile away when SYNTH is defined.
`ifndef POINTER_SHAKE_DETECTOR_DEFINES_SVH
`define POINTER_SHAKE_DETECTOR_DEFINES_SVH

`ifndef SYNTH

// Checked on every rising edge outside reset.
`define PSD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define PSD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PSD_ASSERT(label, prop, msg)
`define PSD_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* rtl/core/psd_pkg.sv */
package psd_pkg;

    localparam int unsigned POS_W    = 32;
    localparam int unsigned TRAVEL_W = 32;
    localparam int unsigned TIME_W   = 64;
    localparam int unsigned WINDOW_W = 32;
    localparam int unsigned TURN_W   = 4;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 32;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_ENABLE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISTANCE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_NS          = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT         = 2'd3;

    // Reset values of the configuration registers
    localparam logic                  RST_DETECT_ENABLE      = 1'b1;
    localparam logic [TRAVEL_W-1:0]   RST_DISTANCE_THRESHOLD = 32'd102400;
    localparam logic [WINDOW_W-1:0]   RST_WINDOW_NS          = 32'd400000000;
    localparam logic [TURN_W-1:0]     RST_TURN_LIMIT         = 4'd3;

    localparam logic [TURN_W-1:0]     TURNS_MAX  = 4'd15;
    localparam logic [TRAVEL_W-1:0]   TRAVEL_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                detect_enable;
        logic [TRAVEL_W-1:0] distance_threshold;
        logic [WINDOW_W-1:0] window_ns;
        logic [TURN_W-1:0]   turn_limit;
    } psd_cfg_t;

    typedef struct packed {
        logic                    cmd;
        logic signed [POS_W-1:0] motion;
        logic [TIME_W-1:0]       timestamp_ns;
    } psd_item_t;

endpackage

/* rtl/core/psd_cfg_regs.sv */
module psd_cfg_regs (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]       cfg_data,
    output psd_pkg::psd_cfg_t                    cfg
);
    import psd_pkg::*;

    psd_cfg_t cfg_reg;
    psd_cfg_t cfg_next;

    // Always take a write
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DETECT_ENABLE:      cfg_next.detect_enable      = cfg_data[0];
                REG_DISTANCE_THRESHOLD: cfg_next.distance_threshold = cfg_data[TRAVEL_W-1:0];
                REG_WINDOW_NS:          cfg_next.window_ns          = cfg_data[WINDOW_W-1:0];
                REG_TURN_LIMIT:         cfg_next.turn_limit         = cfg_data[TURN_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_enable      <= RST_DETECT_ENABLE;
            cfg_reg.distance_threshold <= RST_DISTANCE_THRESHOLD;
            cfg_reg.window_ns          <= RST_WINDOW_NS;
            cfg_reg.turn_limit         <= RST_TURN_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/core/psd_in_stage.sv */
module psd_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  psd_pkg::psd_item_t  in_item,
    output logic                item_valid,
    input  logic                item_take,
    output psd_pkg::psd_item_t  item
);
    import psd_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    psd_item_t item_reg;
    logic      load;

    // Accept when empty or when the held item moves on this cycle
    assign in_ready   = !valid_reg || item_take;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (item_take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Capture the payload on transfer
    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

endmodule

/* rtl/core/psd_track.sv */
`include "pointer_shake_detector_defines.svh"

module psd_track (
    input  logic                           clk,
    input  logic                           rst_n,
    input  psd_pkg::psd_cfg_t              cfg,
    input  logic                           item_valid,
    output logic                           item_take,
    input  psd_pkg::psd_item_t             item,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           shake,
    output logic [psd_pkg::TURN_W-1:0]     turn_count
);
    import psd_pkg::*;

    // Tracking state
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic                dir_reg,    dir_next;
    logic [TRAVEL_W-1:0] travel_reg, travel_next;
    logic [TURN_W-1:0]   turns_reg,  turns_next;
    logic [TIME_W-1:0]   last_reg,   last_next;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                shake_reg,     shake_next;
    logic [TURN_W-1:0]   count_reg;

    // Step and travel
    logic signed [POS_W:0] motion_ext;
    logic signed [POS_W:0] pos_ext;
    logic signed [POS_W:0] step;
    logic [POS_W:0]        mag;
    logic [TRAVEL_W+1:0]   sum;
    logic [TRAVEL_W-1:0]   travel_sat;
    logic                  step_neg;
    logic                  step_pos;
    logic                  reversal;
    logic [TIME_W-1:0]     dt;
    logic                  in_window;
    logic [TURN_W-1:0]     turns_inc;
    logic                  fire;

    // Move an item on when the result slot is free or drains now
    assign fire      = item_valid && (!out_valid_reg || out_ready);
    assign item_take = fire;

    assign motion_ext = {item.motion[POS_W-1], item.motion};
    assign pos_ext    = {pos_reg[POS_W-1], pos_reg};
    assign step       = item.cmd ? (motion_ext - pos_ext) : motion_ext;
    assign mag        = step[POS_W] ? (-step) : step;
    assign sum        = {2'b00, travel_reg} + {1'b0, mag};
    assign travel_sat = (sum > {2'b00, TRAVEL_MAX}) ? TRAVEL_MAX : sum[TRAVEL_W-1:0];

    assign step_neg = step[POS_W];
    assign step_pos = !step[POS_W] && (step != '0);
    assign reversal = (step_neg && !dir_reg) || (step_pos && dir_reg);

    assign dt        = item.timestamp_ns - last_reg;
    assign in_window = (dt[TIME_W-1:WINDOW_W] == '0) && (dt[WINDOW_W-1:0] < cfg.window_ns);
    assign turns_inc = (turns_reg == TURNS_MAX) ? TURNS_MAX : (turns_reg + 1'b1);

    // Update the tracking state for one item
    always_comb
    begin
        pos_next    = pos_reg;
        dir_next    = dir_reg;
        travel_next = travel_reg;
        turns_next  = turns_reg;
        last_next   = last_reg;
        shake_next  = 1'b0;
        if (fire && cfg.detect_enable)
        begin
            pos_next    = item.cmd ? item.motion : (pos_reg + item.motion);
            travel_next = travel_sat;
            if (reversal)
            begin
                dir_next  = !dir_reg;
                last_next = item.timestamp_ns;
                if (!in_window)
                begin
                    turns_next  = '0;
                    travel_next = '0;
                end
                else if (travel_sat > cfg.distance_threshold)
                begin
                    travel_next = '0;
                    if (turns_inc > cfg.turn_limit)
                    begin
                        turns_next = '0;
                        shake_next = 1'b1;
                        last_next  = last_reg;
                    end
                    else
                    begin
                        turns_next = turns_inc;
                    end
                end
            end
        end
    end

    // Track result slot occupancy
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            dir_reg       <= 1'b0;
            travel_reg    <= '0;
            turns_reg     <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            dir_reg       <= dir_next;
            travel_reg    <= travel_next;
            turns_reg     <= turns_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Load the result on each item
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            shake_reg <= shake_next;
            count_reg <= turns_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign shake      = shake_reg;
    assign turn_count = count_reg;

    `PSD_ASSERT(a_shake_clears_count,
        out_valid_reg && shake_reg |-> count_reg == '0,
        "shake reported with nonzero turn count")
    `PSD_ASSERT(a_disabled_holds,
        fire && !cfg.detect_enable |=> $stable(pos_reg) && $stable(travel_reg)
            && $stable(turns_reg) && $stable(last_reg) && !shake_reg,
        "state moved while detection disabled")
    `PSD_ASSERT(a_late_reversal_clears,
        fire && cfg.detect_enable && reversal && !in_window
            |=> travel_reg == '0 && turns_reg == '0,
        "late reversal did not clear history")
    `PSD_ASSERT_ALWAYS(a_no_take_when_idle,
        !item_valid |-> !item_take,
        "item taken from an empty input stage")

endmodule

/* rtl/core/pointer_shake_detector.sv */
// Horizontal pointer shake detector. Each input transfer carries one motion
// (cmd 0: relative step, cmd 1: absolute position, both signed Q24.8) and a
// 64-bit nanosecond timestamp; each produces exactly one result transfer with
// shake and the current turn count. The block takes one item per clock while the
// result side is not stalled: an input register feeds the update logic (step,
// saturating travel sum, reversal and window checks) that writes the tracking
// state and a result register, and input stalls only while the result side is
// stalled. Configuration writes (index 0 enable, 1 distance threshold, 2 window
// in ns, 3 turn limit) are always ready and must only be issued while idle.
module pointer_shake_detector (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [psd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [psd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic signed [psd_pkg::POS_W-1:0]  motion,
    input  logic [psd_pkg::TIME_W-1:0]        timestamp_ns,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              shake,
    output logic [psd_pkg::TURN_W-1:0]        turn_count
);
    import psd_pkg::*;

    psd_cfg_t  cfg;
    psd_item_t in_item;
    psd_item_t item;
    logic      item_valid;
    logic      item_take;

    assign in_item.cmd          = cmd;
    assign in_item.motion       = motion;
    assign in_item.timestamp_ns = timestamp_ns;

    psd_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg)
    );

    psd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    psd_track u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .shake      (shake),
        .turn_count (turn_count)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import psd_pkg::*;

    localparam logic CMD_RELATIVE = 1'b0;
    localparam logic CMD_ABSOLUTE = 1'b1;

    localparam int unsigned RESET_CYCLES  = 8;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned LONG_HOLD     = 300;
    localparam int unsigned STALL_LIMIT   = 3000;
    localparam int unsigned MAX_PRINTS    = 50;

    typedef struct packed {
        logic              shake;
        logic [TURN_W-1:0] turns;
    } shake_result_t;

    // Track pointer motion and hold the results the block owes
    class shake_checker;
        psd_cfg_t          cfg;
        logic [POS_W-1:0]  position;
        logic              dir_neg;
        logic [TRAVEL_W-1:0] travel;
        logic [TURN_W-1:0] turns;
        logic [TIME_W-1:0] last_reversal;
        shake_result_t     owed_results[$];
        int unsigned       mismatches;
        int unsigned       results_seen;

        function new();
            cfg.detect_enable      = RST_DETECT_ENABLE;
            cfg.distance_threshold = RST_DISTANCE_THRESHOLD;
            cfg.window_ns          = RST_WINDOW_NS;
            cfg.turn_limit         = RST_TURN_LIMIT;
            position      = '0;
            dir_neg       = 1'b0;
            travel        = '0;
            turns         = '0;
            last_reversal = '0;
            mismatches    = 0;
            results_seen  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_DETECT_ENABLE:      cfg.detect_enable = data[0];
                REG_DISTANCE_THRESHOLD: cfg.distance_threshold = data;
                REG_WINDOW_NS:          cfg.window_ns = data;
                REG_TURN_LIMIT:         cfg.turn_limit = data[TURN_W-1:0];
                default: ;
            endcase
        endfunction

        // Advance the tracking state by one accepted motion and queue its result
        function void note_motion(psd_item_t item);
            longint            step;
            longint unsigned   mag;
            longint unsigned   total;
            logic [TIME_W-1:0] dt;
            logic              reported;
            shake_result_t     res;

            res.shake = 1'b0;
            if (cfg.detect_enable)
            begin
                if (item.cmd == CMD_ABSOLUTE)
                begin
                    step = longint'($signed(item.motion)) - longint'($signed(position));
                    position = item.motion;
                end
                else
                begin
                    step = longint'($signed(item.motion));
                    position = position + item.motion;
                end

                // Saturate the travelled distance
                mag   = (step < 0) ? longint'(-step) : longint'(step);
                total = longint'(travel) + mag;
                travel = (total > longint'(TRAVEL_MAX)) ? TRAVEL_MAX : total[TRAVEL_W-1:0];

                if ((step < 0 && !dir_neg) || (step > 0 && dir_neg))
                begin
                    dt = item.timestamp_ns - last_reversal;
                    reported = 1'b0;
                    dir_neg = !dir_neg;
                    if (dt < TIME_W'(cfg.window_ns))
                    begin
                        if (travel > cfg.distance_threshold)
                        begin
                            if (turns < TURNS_MAX)
                                turns = turns + 1'b1;
                            travel = '0;
                            if (turns > cfg.turn_limit)
                            begin
                                turns = '0;
                                res.shake = 1'b1;
                                reported = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        // Window expired: drop the history
                        turns = '0;
                        travel = '0;
                    end
                    if (!reported)
                        last_reversal = item.timestamp_ns;
                end
            end
            res.turns = turns;
            owed_results.push_back(res);
        endfunction

        function int unsigned pending_count();
            return owed_results.size();
        endfunction

        task report_mismatch(string msg);
            if (mismatches < MAX_PRINTS)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        // Compare one result transfer with the oldest owed result
        task check_result(logic shake_bit, logic [TURN_W-1:0] count);
            shake_result_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch("result transfer with nothing owed");
                return;
            end
            want = owed_results.pop_front();
            if (shake_bit !== want.shake)
                report_mismatch($sformatf("result %0d shake %b, want %b",
                                          results_seen, shake_bit, want.shake));
            if (count !== want.turns)
                report_mismatch($sformatf("result %0d turn_count %0d, want %0d",
                                          results_seen, count, want.turns));
            results_seen++;
        endtask

        task check_leftover();
            if (owed_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", owed_results.size()));
        endtask
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic                    cmd;
    logic signed [POS_W-1:0] motion;
    logic [TIME_W-1:0]       timestamp_ns;
    logic                    out_valid;
    logic                    out_ready;
    logic                    shake;
    logic [TURN_W-1:0]       turn_count;

    shake_checker            tracker;
    logic [TIME_W-1:0]       now_ns;
    logic signed [POS_W-1:0] cursor;
    int unsigned             items_sent;
    int unsigned             idle_cycles;
    bit                      tx_eager;
    bit                      rx_eager;
    bit                      rx_long_hold;

    pointer_shake_detector u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .motion       (motion),
        .timestamp_ns (timestamp_ns),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .shake        (shake),
        .turn_count   (turn_count)
    );

    always #2 clk = ~clk;

    function automatic int unsigned draw_gap(bit eager);
        if (eager || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Offer one motion after a random gap and hold it until the transfer
    task automatic send_item(logic cmd_bit, logic signed [POS_W-1:0] value,
                             logic [TIME_W-1:0] stamp);
        int unsigned gap;
        psd_item_t   item;
        gap = draw_gap(tx_eager);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item.cmd          = cmd_bit;
        item.motion       = value;
        item.timestamp_ns = stamp;
        in_valid     = 1'b1;
        cmd          = cmd_bit;
        motion       = value;
        timestamp_ns = stamp;
        do @(posedge clk); while (!in_ready);
        tracker.note_motion(item);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_step(bit absolute, logic signed [POS_W-1:0] delta);
        cursor = cursor + delta;
        if (absolute)
            send_item(CMD_ABSOLUTE, cursor, now_ns);
        else
            send_item(CMD_RELATIVE, delta, now_ns);
    endtask

    // Back-and-forth strokes, each a few steps in one direction
    task automatic shake_gesture(int unsigned strokes, bit absolute);
        int unsigned             k;
        int unsigned             j;
        int unsigned             steps;
        logic signed [POS_W-1:0] delta;
        bit                      neg;
        neg = 1'($urandom_range(0, 1));
        for (k = 0; k < strokes; k++)
        begin
            steps = $urandom_range(1, 4);
            for (j = 0; j < steps; j++)
            begin
                delta = $urandom_range(32 * 256, 300 * 256);
                if ($urandom_range(0, 19) == 0)
                    delta = '0;
                if (neg)
                    delta = -delta;
                now_ns = now_ns + TIME_W'($urandom_range(1_000_000, 40_000_000));
                send_step(absolute, delta);
            end
            neg = !neg;
        end
    endtask

    task automatic noise_item();
        logic [TIME_W-1:0] stamp;
        case ($urandom_range(0, 3))
            0:
            begin
                stamp = {$urandom, $urandom};
                send_item(1'($urandom_range(0, 1)), $urandom, stamp);
            end
            1:
            begin
                now_ns = now_ns + TIME_W'($urandom_range(0, 1_000_000_000));
                send_step(1'($urandom_range(0, 1)),
                          $signed(32'($urandom_range(0, 4096))) - 2048);
            end
            2:
            begin
                cursor = $urandom;
                send_item(CMD_ABSOLUTE, cursor, now_ns);
            end
            default:
            begin
                now_ns = now_ns + TIME_W'($urandom_range(500_000_000, 2_000_000_000));
                send_step(1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? 32'sd0 : -32'sd256);
            end
        endcase
    endtask

    // Mostly gestures with random content, the rest noise
    task automatic run_mix(int unsigned count);
        int unsigned target;
        target = items_sent + count;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) < 7)
                shake_gesture($urandom_range(2, 8), 1'($urandom_range(0, 1)));
            else
                noise_item();
        end
    endtask

    task automatic stop_input();
        in_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (tracker.pending_count() != 0)
            @(negedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        tracker.write_reg(idx, data);
        @(negedge clk);
    endtask

    // Drain the block, then rewrite every register
    task automatic program_regs(logic [CFG_DATA_W-1:0] enable_word,
                                logic [CFG_DATA_W-1:0] threshold,
                                logic [CFG_DATA_W-1:0] window,
                                logic [CFG_DATA_W-1:0] limit_word);
        stop_input();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write(REG_DETECT_ENABLE, enable_word);
        cfg_write(REG_DISTANCE_THRESHOLD, threshold);
        cfg_write(REG_WINDOW_NS, window);
        cfg_write(REG_TURN_LIMIT, limit_word);
        cfg_valid = 1'b0;
    endtask

    // Receiver: stall a random gap before each result, or a long hold once when asked
    task automatic receive_loop();
        int unsigned hold;
        forever
        begin
            if (rx_long_hold)
                hold = LONG_HOLD;
            else
                hold = draw_gap(rx_eager);
            rx_long_hold = 1'b0;
            if (hold > 0)
            begin
                out_ready = 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
            @(negedge clk);
        end
    endtask

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            tracker.check_result(shake, turn_count);
    end

    // Watchdog: end the run after too long without any transfer
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        receive_loop();
    end

    initial
    begin
        tracker      = new();
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        cmd          = CMD_RELATIVE;
        motion       = '0;
        timestamp_ns = '0;
        out_ready    = 1'b0;
        items_sent   = 0;
        tx_eager     = 1'b0;
        rx_eager     = 1'b0;
        rx_long_hold = 1'b0;
        cursor       = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: zero step, extreme steps, position wrap, travel saturation
        send_item(CMD_RELATIVE, 32'sd0, 64'd0);
        send_item(CMD_RELATIVE, 32'sh7FFF_FFFF, 64'd1000);
        send_item(CMD_RELATIVE, 32'sh7FFF_FFFF, 64'd2000);
        send_item(CMD_RELATIVE, 32'sh7FFF_FFFF, 64'd3000);
        send_item(CMD_RELATIVE, 32'sh8000_0000, 64'd4000);
        // Absolute positions: widest difference both ways, then no move
        send_item(CMD_ABSOLUTE, 32'sh8000_0000, 64'd5000);
        send_item(CMD_ABSOLUTE, 32'sh7FFF_FFFF, 64'd6000);
        send_item(CMD_ABSOLUTE, 32'sh8000_0000, 64'd7000);
        send_item(CMD_ABSOLUTE, 32'sh8000_0000, 64'd8000);
        // Fast reversals up to a reported shake
        send_item(CMD_RELATIVE, 32'sh0002_0000, 64'd10_000_000);
        send_item(CMD_RELATIVE, -32'sh0002_0000, 64'd20_000_000);
        send_item(CMD_RELATIVE, 32'sh0002_0000, 64'd30_000_000);
        send_item(CMD_RELATIVE, -32'sh0002_0000, 64'd40_000_000);
        send_item(CMD_RELATIVE, 32'sh0002_0000, 64'd50_000_000);
        send_item(CMD_RELATIVE, -32'sh0002_0000, 64'd60_000_000);
        send_item(CMD_RELATIVE, 32'sh0002_0000, 64'd70_000_000);
        // Reversals after the window has expired
        send_item(CMD_RELATIVE, -32'sh0002_0000, 64'd2_000_000_000);
        send_item(CMD_RELATIVE, 32'sh0002_0000, 64'd3_000_000_000);
        // Elapsed time across the timestamp wrap
        send_item(CMD_RELATIVE, -32'sh0003_0000, 64'hFFFF_FFFF_FFFF_FFF0);
        send_item(CMD_RELATIVE, 32'sh0003_0000, 64'd5);
        send_item(CMD_RELATIVE, -32'sd1, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(CMD_RELATIVE, 32'sd1, 64'd0);

        now_ns = 64'd10_000_000_000;
        cursor = '0;

        // Default settings written explicitly
        program_regs(32'd1, RST_DISTANCE_THRESHOLD, RST_WINDOW_NS, 32'(RST_TURN_LIMIT));
        run_mix(300);

        // No distance needed, widest window, shake on the first turn
        tx_eager = 1'b1;
        program_regs(32'd1, 32'd0, 32'hFFFF_FFFF, 32'd0);
        run_mix(200);

        // Short window across the timestamp wrap, limit fourteen
        tx_eager = 1'b0;
        rx_eager = 1'b1;
        now_ns = 64'hFFFF_FFFF_FFFF_FFFF - 64'd300_000_000;
        program_regs(32'd1, 32'd25600, 32'd100_000_000, 32'd14);
        run_mix(200);

        // Limit fifteen: turns saturate
        tx_eager = 1'b1;
        program_regs(32'd1, 32'd8, 32'd400_000_000, 32'd15);
        run_mix(200);

        // Detection off: state held
        tx_eager = 1'b0;
        rx_eager = 1'b0;
        program_regs($urandom & ~32'd1, $urandom, $urandom, 32'($urandom_range(0, 15)));
        run_mix(100);

        // Unreachable threshold and an empty window
        program_regs(32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1);
        run_mix(100);

        // Random settings with junk in the unused register bits
        program_regs({31'($urandom_range(0, 32'h7FFF_FFFF)), 1'b1},
                     $urandom_range(0, 200_000),
                     $urandom_range(0, 600_000_000),
                     {28'($urandom_range(0, 32'h0FFF_FFFF)), 4'($urandom_range(0, 15))});
        run_mix(250);

        // Back to defaults under pressure
        program_regs(32'd1, RST_DISTANCE_THRESHOLD, RST_WINDOW_NS, 32'(RST_TURN_LIMIT));
        run_mix(100);
        rx_long_hold = 1'b1;
        run_mix(100);
        stop_input();
        wait_drained();
        run_mix(100);

        stop_input();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        tracker.check_leftover();
        if (tracker.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* pointer_shake_detector.f */
+incdir+rtl/core
rtl/core/psd_pkg.sv
rtl/core/psd_cfg_regs.sv
rtl/core/psd_in_stage.sv
rtl/core/psd_track.sv
rtl/core/pointer_shake_detector.sv
dv/tb_top.sv
